### rtl/acf_pkg.sv
`default_nettype none

package acf_pkg;

  // Field widths
  localparam int unsigned VAL_W  = 32;  // Q16.16 values
  localparam int unsigned GAIN_W = 18;  // Q2.16 gains
  localparam int unsigned STEP_W = 16;  // Q0.16 timestep

  // Shared multiplier geometry: signed multiplicand, unsigned multiplier
  localparam int unsigned MCAND_W   = 36;
  localparam int unsigned MPLIER_W  = GAIN_W;
  localparam int unsigned PROD_W    = MCAND_W + MPLIER_W;
  localparam int unsigned MUL_STEPS = MPLIER_W;
  localparam int unsigned MUL_CNT_W = $clog2(MUL_STEPS);

  // Rounded product after dropping 16 fraction bits
  localparam int unsigned RND_W = PROD_W - 16;
  // Width used for saturating sums
  localparam int unsigned SUM_W = 40;

  // Configuration register indexes
  localparam logic [1:0] CFG_GAIN_POSITION = 2'd0;
  localparam logic [1:0] CFG_GAIN_VELOCITY = 2'd1;
  localparam logic [1:0] CFG_GAIN_ACCEL    = 2'd2;

  // Gain reset values
  localparam logic [GAIN_W-1:0] GAIN_POSITION_RST = 18'd56174;
  localparam logic [GAIN_W-1:0] GAIN_VELOCITY_RST = 18'd16050;
  localparam logic [GAIN_W-1:0] GAIN_ACCEL_RST    = 18'd1529;

  // Multiply sequence, one entry per product
  localparam logic [2:0] OP_ERR_ACCEL  = 3'd0;  // e * gain_accel
  localparam logic [2:0] OP_BIAS_STEP  = 3'd1;  // (..) * T -> accel_bias
  localparam logic [2:0] OP_ERR_VEL    = 3'd2;  // e * gain_velocity
  localparam logic [2:0] OP_VEL_STEP   = 3'd3;  // (..) * T -> velocity
  localparam logic [2:0] OP_ERR_POS    = 3'd4;  // e * gain_position
  localparam logic [2:0] OP_POS_STEP   = 3'd5;  // (..) * T -> position_correction
  localparam logic [2:0] OP_INC        = 3'd6;  // sat(accel + bias) * T
  localparam logic [2:0] OP_BASE       = 3'd7;  // (2v + inc) * T, half

  typedef struct packed {
    logic [GAIN_W-1:0] position;
    logic [GAIN_W-1:0] velocity;
    logic [GAIN_W-1:0] accel;
  } gains_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] accel_z;
    logic signed [VAL_W-1:0] pos_error;
    logic [STEP_W-1:0]       step_time;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] base_altitude;
    logic signed [VAL_W-1:0] climb_rate;
    logic signed [VAL_W-1:0] altitude;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_RUN    = 5'b00100,
    ST_APPLY  = 5'b01000,
    ST_FINISH = 5'b10000
  } state_t;

  // Clamp a wide signed sum to the 32-bit signed range
  function automatic logic signed [VAL_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi_lim;
    logic signed [SUM_W-1:0] lo_lim;
    hi_lim = SUM_W'(64'sd2147483647);
    lo_lim = -SUM_W'(64'sd2147483648);
    if (v > hi_lim) begin
      sat32 = 32'sh7FFF_FFFF;
    end else if (v < lo_lim) begin
      sat32 = 32'sh8000_0000;
    end else begin
      sat32 = v[VAL_W-1:0];
    end
  endfunction

endpackage

`default_nettype wire

### rtl/acf_serial_mult.sv
`default_nettype none

// Radix-2 shift-add multiplier: signed multiplicand times unsigned
// multiplier, one multiplier bit retired per cycle.
module acf_serial_mult (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire logic                                   start,
  input  wire logic signed [acf_pkg::MCAND_W-1:0]     mcand,
  input  wire logic [acf_pkg::MPLIER_W-1:0]           mplier,
  output logic                                        busy,
  output logic signed [acf_pkg::PROD_W-1:0]           product
);

  logic                                   running;
  logic [acf_pkg::MUL_CNT_W-1:0]          cnt;
  logic signed [acf_pkg::MCAND_W-1:0]     mcand_q;
  logic signed [acf_pkg::MCAND_W:0]       hi;
  logic [acf_pkg::MPLIER_W-1:0]           lo;
  logic signed [acf_pkg::MCAND_W:0]       partial;

  // Add the multiplicand into the upper half when the current bit is set
  always_comb begin
    partial = hi + (lo[0] ? {mcand_q[acf_pkg::MCAND_W-1], mcand_q}
                          : {(acf_pkg::MCAND_W+1){1'b0}});
  end

  // Step control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      cnt     <= '0;
    end else if (start) begin
      running <= 1'b1;
      cnt     <= '0;
    end else if (running) begin
      cnt <= cnt + 1'b1;
      if (cnt == acf_pkg::MUL_CNT_W'(acf_pkg::MUL_STEPS - 1)) begin
        running <= 1'b0;
      end
    end
  end

  // Product shift register
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_q <= mcand;
      hi      <= '0;
      lo      <= mplier;
    end else if (running) begin
      hi <= {partial[acf_pkg::MCAND_W], partial[acf_pkg::MCAND_W:1]};
      lo <= {partial[0], lo[acf_pkg::MPLIER_W-1:1]};
    end
  end

  assign busy    = running;
  assign product = {hi[acf_pkg::MCAND_W-1:0], lo};

endmodule

`default_nettype wire

### rtl/acf_core.sv
`default_nettype none

// Filter state and the sequencer that walks the eight products through
// the shared serial multiplier.
module acf_core (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire acf_pkg::item_t    item,
  input  wire acf_pkg::gains_t   gains,
  output logic                   idle,
  output logic                   res_valid,
  input  wire logic              res_ready,
  output acf_pkg::result_t       result
);

  acf_pkg::state_t state;
  logic [2:0]      op;

  acf_pkg::item_t  item_q;

  logic signed [acf_pkg::VAL_W-1:0]   accel_bias;
  logic signed [acf_pkg::VAL_W-1:0]   velocity;
  logic signed [acf_pkg::VAL_W-1:0]   position_correction;
  logic signed [acf_pkg::VAL_W-1:0]   position_base;
  logic signed [acf_pkg::MCAND_W-1:0] scaled_err;
  logic signed [33:0]                 inc;

  logic                                mul_start;
  logic signed [acf_pkg::MCAND_W-1:0]  mcand;
  logic [acf_pkg::MPLIER_W-1:0]        mplier;
  logic                                mul_busy;
  logic signed [acf_pkg::PROD_W-1:0]   product;

  logic signed [acf_pkg::VAL_W-1:0]    accel_sum;
  logic signed [acf_pkg::MCAND_W-1:0]  twice_vel_inc;
  logic signed [acf_pkg::PROD_W-1:0]   rounded;
  logic signed [acf_pkg::RND_W-1:0]    rnd;
  logic signed [acf_pkg::SUM_W-1:0]    rnd_ext;
  logic [acf_pkg::MPLIER_W-1:0]        step_ext;

  acf_serial_mult u_mult (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .mcand   (mcand),
    .mplier  (mplier),
    .busy    (mul_busy),
    .product (product)
  );

  assign step_ext = {{(acf_pkg::MPLIER_W-acf_pkg::STEP_W){1'b0}}, item_q.step_time};

  // Corrected acceleration and the trapezoid sum
  always_comb begin
    accel_sum = acf_pkg::sat32(
        {{(acf_pkg::SUM_W-acf_pkg::VAL_W){item_q.accel_z[acf_pkg::VAL_W-1]}}, item_q.accel_z}
      + {{(acf_pkg::SUM_W-acf_pkg::VAL_W){accel_bias[acf_pkg::VAL_W-1]}}, accel_bias});
    twice_vel_inc = {{3{velocity[acf_pkg::VAL_W-1]}}, velocity, 1'b0}
                  + {{2{inc[33]}}, inc};
  end

  // Select operands for the current product
  always_comb begin
    mul_start = (state == acf_pkg::ST_LOAD);
    case (op)
      acf_pkg::OP_ERR_ACCEL: begin
        mcand  = {{4{item_q.pos_error[acf_pkg::VAL_W-1]}}, item_q.pos_error};
        mplier = gains.accel;
      end
      acf_pkg::OP_ERR_VEL: begin
        mcand  = {{4{item_q.pos_error[acf_pkg::VAL_W-1]}}, item_q.pos_error};
        mplier = gains.velocity;
      end
      acf_pkg::OP_ERR_POS: begin
        mcand  = {{4{item_q.pos_error[acf_pkg::VAL_W-1]}}, item_q.pos_error};
        mplier = gains.position;
      end
      acf_pkg::OP_BIAS_STEP, acf_pkg::OP_VEL_STEP, acf_pkg::OP_POS_STEP: begin
        mcand  = scaled_err;
        mplier = step_ext;
      end
      acf_pkg::OP_INC: begin
        mcand  = {{4{accel_sum[acf_pkg::VAL_W-1]}}, accel_sum};
        mplier = step_ext;
      end
      acf_pkg::OP_BASE: begin
        mcand  = twice_vel_inc;
        mplier = step_ext;
      end
      default: begin
        mcand  = '0;
        mplier = '0;
      end
    endcase
  end

  // Round the product half up; the base update also halves it
  always_comb begin
    if (op == acf_pkg::OP_BASE) begin
      rounded = product + acf_pkg::PROD_W'(64'sd65536);
      rnd     = {rounded[acf_pkg::PROD_W-1], rounded[acf_pkg::PROD_W-1:17]};
    end else begin
      rounded = product + acf_pkg::PROD_W'(64'sd32768);
      rnd     = rounded[acf_pkg::PROD_W-1:16];
    end
    rnd_ext = {{(acf_pkg::SUM_W-acf_pkg::RND_W){rnd[acf_pkg::RND_W-1]}}, rnd};
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= acf_pkg::ST_IDLE;
      op    <= acf_pkg::OP_ERR_ACCEL;
    end else begin
      case (state)
        acf_pkg::ST_IDLE: begin
          if (start) begin
            op    <= acf_pkg::OP_ERR_ACCEL;
            state <= acf_pkg::ST_LOAD;
          end
        end
        acf_pkg::ST_LOAD: begin
          state <= acf_pkg::ST_RUN;
        end
        acf_pkg::ST_RUN: begin
          if (!mul_busy) begin
            state <= acf_pkg::ST_APPLY;
          end
        end
        acf_pkg::ST_APPLY: begin
          if (op == acf_pkg::OP_BASE) begin
            state <= acf_pkg::ST_FINISH;
          end else begin
            op    <= op + 1'b1;
            state <= acf_pkg::ST_LOAD;
          end
        end
        acf_pkg::ST_FINISH: begin
          if (res_ready) begin
            state <= acf_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= acf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // Latch the item at start
  always_ff @(posedge clk) begin
    if (state == acf_pkg::ST_IDLE && start) begin
      item_q <= item;
    end
  end

  // Apply each rounded product to the filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      accel_bias          <= '0;
      velocity            <= '0;
      position_correction <= '0;
      position_base       <= '0;
    end else if (state == acf_pkg::ST_APPLY) begin
      case (op)
        acf_pkg::OP_ERR_ACCEL, acf_pkg::OP_ERR_VEL, acf_pkg::OP_ERR_POS: begin
          scaled_err <= rnd[acf_pkg::MCAND_W-1:0];
        end
        acf_pkg::OP_BIAS_STEP: begin
          accel_bias <= acf_pkg::sat32(rnd_ext +
            {{(acf_pkg::SUM_W-acf_pkg::VAL_W){accel_bias[acf_pkg::VAL_W-1]}}, accel_bias});
        end
        acf_pkg::OP_VEL_STEP: begin
          velocity <= acf_pkg::sat32(rnd_ext +
            {{(acf_pkg::SUM_W-acf_pkg::VAL_W){velocity[acf_pkg::VAL_W-1]}}, velocity});
        end
        acf_pkg::OP_POS_STEP: begin
          position_correction <= acf_pkg::sat32(rnd_ext +
            {{(acf_pkg::SUM_W-acf_pkg::VAL_W){position_correction[acf_pkg::VAL_W-1]}},
             position_correction});
        end
        acf_pkg::OP_INC: begin
          inc <= rnd[33:0];
        end
        acf_pkg::OP_BASE: begin
          position_base <= acf_pkg::sat32(rnd_ext +
            {{(acf_pkg::SUM_W-acf_pkg::VAL_W){position_base[acf_pkg::VAL_W-1]}},
             position_base});
          velocity <= acf_pkg::sat32(
            {{(acf_pkg::SUM_W-34){inc[33]}}, inc} +
            {{(acf_pkg::SUM_W-acf_pkg::VAL_W){velocity[acf_pkg::VAL_W-1]}}, velocity});
        end
        default: begin
          accel_bias <= accel_bias;
        end
      endcase
    end
  end

  // Result from the updated state
  always_comb begin
    idle      = (state == acf_pkg::ST_IDLE);
    res_valid = (state == acf_pkg::ST_FINISH);
    result.altitude = acf_pkg::sat32(
        {{(acf_pkg::SUM_W-acf_pkg::VAL_W){position_base[acf_pkg::VAL_W-1]}}, position_base}
      + {{(acf_pkg::SUM_W-acf_pkg::VAL_W){position_correction[acf_pkg::VAL_W-1]}},
         position_correction});
    result.climb_rate    = velocity;
    result.base_altitude = position_base;
  end

endmodule

`default_nettype wire

### rtl/altitude_complementary_filter_top.sv
`default_nettype none

// Channel   Direction  Transaction                    Payload
// s_axis    in         s_axis_tvalid & s_axis_tready  accel_z, pos_error, step_time; hold
// m_axis    out        m_axis_tvalid & m_axis_tready  altitude, climb_rate, base_altitude
// cfg       in         cfg_we                         gain_position/velocity/accel
//
// One item at a time: eight products through one 18-step serial multiplier, and a
// result lands in the output register once that register is free; the next item is
// accepted as soon as the core idles. A held item is accepted and dropped. Reset is
// synchronous and clears the filter state and restores the default gains. The output
// register holds a result under back-pressure while the core takes the next item.
module altitude_complementary_filter_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [79:0] s_axis_tdata,  // accel_z[31:0], pos_error[63:32], step_time[79:64]
  input  wire logic [0:0]  s_axis_tuser,  // hold[0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [95:0]      m_axis_tdata,  // altitude[31:0], climb_rate[63:32], base_altitude[95:64]
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [17:0] cfg_data
);

  acf_pkg::gains_t  gains;
  acf_pkg::item_t   item;
  acf_pkg::result_t result;
  logic             core_idle;
  logic             core_start;
  logic             res_valid;
  logic             res_ready;

  // Gain registers
  always_ff @(posedge clk) begin
    if (rst) begin
      gains.position <= acf_pkg::GAIN_POSITION_RST;
      gains.velocity <= acf_pkg::GAIN_VELOCITY_RST;
      gains.accel    <= acf_pkg::GAIN_ACCEL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        acf_pkg::CFG_GAIN_POSITION: gains.position <= cfg_data;
        acf_pkg::CFG_GAIN_VELOCITY: gains.velocity <= cfg_data;
        acf_pkg::CFG_GAIN_ACCEL:    gains.accel    <= cfg_data;
        default:                    gains          <= gains;
      endcase
    end
  end

  // Unpack the input transaction; drop held items
  always_comb begin
    item.accel_z   = s_axis_tdata[31:0];
    item.pos_error = s_axis_tdata[63:32];
    item.step_time = s_axis_tdata[79:64];
    s_axis_tready  = core_idle;
    core_start     = s_axis_tvalid && core_idle && !s_axis_tuser[0];
  end

  acf_core u_core (
    .clk       (clk),
    .rst       (rst),
    .start     (core_start),
    .item      (item),
    .gains     (gains),
    .idle      (core_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .result    (result)
  );

  assign res_ready = !m_axis_tvalid || m_axis_tready;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_axis_tdata <= {result.base_altitude, result.climb_rate, result.altitude};
    end
  end

endmodule

`default_nettype wire

### verif/altitude_filter_checker.sv
module altitude_filter_checker
  import acf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // accel_z[31:0], pos_error[63:32], step_time[79:64]
  input  logic [0:0]  s_axis_tuser,  // hold[0]
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [95:0] m_axis_tdata,  // altitude[31:0], climb_rate[63:32], base_altitude[95:64]
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [17:0] cfg_data,
  output int          error_count,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // Shadow copy of the filter: gains and the four state words
  gains_t                  gains;
  logic signed [VAL_W-1:0] accel_bias;
  logic signed [VAL_W-1:0] velocity;
  logic signed [VAL_W-1:0] pos_corr;
  logic signed [VAL_W-1:0] pos_base;

  result_t     fused_q[$];
  result_t     got;
  result_t     want;
  int unsigned result_num;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: result %0d: %s", $time, result_num, msg);
    error_count++;
  endtask

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // Drop s fraction bits, rounding half toward plus infinity
  function automatic longint round_drop(input longint v, input int unsigned s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  // Error scaled by a gain and by the timestep
  function automatic longint correction(input longint err, input logic [GAIN_W-1:0] gain,
                                        input longint dt);
    return round_drop(round_drop(err * longint'(gain), 16) * dt, 16);
  endfunction

  // Advance the shadow filter by one item and return the fused output
  function automatic result_t advance_filter(input logic signed [VAL_W-1:0] acc,
                                             input logic signed [VAL_W-1:0] err,
                                             input logic [STEP_W-1:0] step);
    longint  dt;
    longint  ab;
    longint  vel;
    longint  pc;
    longint  pb;
    longint  inc;
    result_t res;
    dt  = longint'(step);
    ab  = clamp32(longint'(accel_bias) + correction(err, gains.accel, dt));
    vel = clamp32(longint'(velocity) + correction(err, gains.velocity, dt));
    pc  = clamp32(longint'(pos_corr) + correction(err, gains.position, dt));
    // Trapezoidal integration: base moves by half of (2v + inc) * T
    inc = round_drop(clamp32(longint'(acc) + ab) * dt, 16);
    pb  = clamp32(longint'(pos_base) + round_drop((2 * vel + inc) * dt, 17));
    vel = clamp32(vel + inc);
    accel_bias = 32'(ab);
    velocity   = 32'(vel);
    pos_corr   = 32'(pc);
    pos_base   = 32'(pb);
    res.altitude      = 32'(clamp32(pb + pc));
    res.climb_rate    = 32'(vel);
    res.base_altitude = 32'(pb);
    return res;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      gains.position = GAIN_POSITION_RST;
      gains.velocity = GAIN_VELOCITY_RST;
      gains.accel    = GAIN_ACCEL_RST;
      accel_bias = '0;
      velocity   = '0;
      pos_corr   = '0;
      pos_base   = '0;
      fused_q.delete();
      outstanding <= 0;
    end else begin
      // Track gain writes; an unused index changes nothing
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN_POSITION: gains.position = cfg_data;
          CFG_GAIN_VELOCITY: gains.velocity = cfg_data;
          CFG_GAIN_ACCEL:    gains.accel    = cfg_data;
          default: ;
        endcase
      end
      // Compare each output transaction with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (fused_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
        end else begin
          want = fused_q.pop_front();
          if (got.altitude !== want.altitude) begin
            report_mismatch($sformatf("altitude %h, expected %h", got.altitude, want.altitude));
          end
          if (got.climb_rate !== want.climb_rate) begin
            report_mismatch($sformatf("climb_rate %h, expected %h",
                                      got.climb_rate, want.climb_rate));
          end
          if (got.base_altitude !== want.base_altitude) begin
            report_mismatch($sformatf("base_altitude %h, expected %h",
                                      got.base_altitude, want.base_altitude));
          end
        end
        result_num++;
      end
      // Predict on each input transaction; held items leave the filter alone
      if (s_axis_tvalid && s_axis_tready && !s_axis_tuser[0]) begin
        fused_q.push_back(advance_filter(s_axis_tdata[31:0], s_axis_tdata[63:32],
                                         s_axis_tdata[79:64]));
      end
      outstanding <= fused_q.size();
    end
  end

endmodule

### verif/altitude_complementary_filter_top_test.sv
module altitude_complementary_filter_top_test;
  import acf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0]  CFG_UNUSED   = 2'd3;
  localparam logic [17:0] GAIN_MAX     = 18'h3FFFF;
  localparam int          DRAIN_CYCLES = 250;
  localparam int          PHASES       = 6;
  localparam int          PHASE_ITEMS  = 280;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;  // accel_z[31:0], pos_error[63:32], step_time[79:64]
  logic [0:0]  s_axis_tuser = '0;  // hold[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;       // altitude[31:0], climb_rate[63:32], base_altitude[95:64]
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [17:0] cfg_data = '0;

  int          error_count;
  int          outstanding;
  logic        quiet = 1'b0;
  int unsigned stall_left = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  altitude_complementary_filter_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  altitude_filter_checker fusion_check (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .error_count   (error_count),
    .outstanding   (outstanding)
  );

  // Back-pressure on the result side: short random stalls, rare long ones
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      stall_left    <= 0;
    end else if (stall_left != 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else if (!quiet && $urandom_range(999) < 2) begin
      m_axis_tready <= 1'b0;
      stall_left    <= $urandom_range(300);
    end else begin
      m_axis_tready <= quiet || ($urandom_range(99) >= 34);
    end
  end

  // Value in Q16.16: mostly a plausible reading within +/- span, else wild bits
  function automatic logic [31:0] pick_value(input int span, input int unsigned wild);
    int unsigned k;
    if ($urandom_range(99) >= wild) begin
      return 32'((int'($urandom_range(2 * span)) - span) * 65536 + int'($urandom_range(65535)));
    end
    k = $urandom_range(9);
    if (k < 6) return $urandom();
    if (k < 8) return 32'($signed($urandom()) >>> $urandom_range(31));
    case ($urandom_range(3))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      default: return 32'hFFFF_FFFF;
    endcase
  endfunction

  // Timestep: mostly up to 0.1 s, else anything up to the full range
  function automatic logic [15:0] pick_step(input int unsigned wild);
    if ($urandom_range(99) >= wild) return 16'($urandom_range(1, 6554));
    case ($urandom_range(4))
      0, 1:    return 16'($urandom());
      2:       return 16'hFFFF;
      3:       return 16'h0000;
      default: return 16'($urandom_range(6554, 65535));
    endcase
  endfunction

  // Present one item and hold it until the transaction completes
  task automatic send_item(input logic [31:0] accel, input logic [31:0] err,
                           input logic [15:0] step, input logic hold);
    if (!quiet && $urandom_range(99) < 3) begin
      repeat ($urandom_range(1, 200)) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    while (!quiet && $urandom_range(99) < 34) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {step, err, accel};
    s_axis_tuser  <= hold;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stop sending, let every predicted result arrive, then let the core settle
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Write all three gains plus one write to the unused index
  task automatic program_gains(input logic [17:0] g_pos, input logic [17:0] g_vel,
                               input logic [17:0] g_acc);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GAIN_POSITION;
    cfg_data  <= g_pos;
    @(posedge clk);
    cfg_index <= CFG_GAIN_VELOCITY;
    cfg_data  <= g_vel;
    @(posedge clk);
    cfg_index <= CFG_GAIN_ACCEL;
    cfg_data  <= g_acc;
    @(posedge clk);
    cfg_index <= CFG_UNUSED;
    cfg_data  <= 18'($urandom_range(262143));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned sent;
    int unsigned wild;
    logic        hold;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed items at the reset gains: extremes, rounding, saturation, holds
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b1);
    send_item(32'h0000_0000, 32'h0000_0000, 16'h0000, 1'b0);
    send_item(32'h0000_0001, 32'h0000_0001, 16'h0001, 1'b0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0);
    send_item(32'h0000_8000, 32'hFFFF_8000, 16'h8000, 1'b0);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    send_item(32'h7FFF_FFFF, 32'h0000_0000, 16'hFFFF, 1'b0);
    send_item($urandom(), $urandom(), 16'($urandom()), 1'b1);
    send_item(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 1'b0);
    send_item(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 1'b0);
    send_item(32'h8000_0000, 32'h8000_0000, 16'hFFFF, 1'b0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b0);
    send_item(32'h0001_0000, 32'hFFFF_0000, 16'h0001, 1'b0);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 16'h8000, 1'b0);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 1'b0);
    send_item(32'h03D5_0000, 32'h0064_0000, 16'h00A4, 1'b0);
    send_item(32'hFC2B_0000, 32'hFF9C_0000, 16'h0147, 1'b0);
    send_item(32'h0000_0000, 32'h0001_8000, 16'h0290, 1'b0);
    wait_drained();

    // Random phases, each under its own gain setting
    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: program_gains(GAIN_MAX, GAIN_MAX, GAIN_MAX);
        1: program_gains('0, '0, '0);
        2: program_gains(GAIN_POSITION_RST, GAIN_VELOCITY_RST, GAIN_ACCEL_RST);
        3: program_gains(18'($urandom_range(262143)), 18'($urandom_range(262143)),
                         18'($urandom_range(262143)));
        4: program_gains(GAIN_MAX, '0, 18'($urandom_range(262143)));
        default: program_gains(18'($urandom_range(1, 300)), 18'($urandom_range(262143)),
                               18'($urandom_range(20000)));
      endcase
      wild = (phase == 1 || phase == 4) ? 5 : 30;
      // One phase opens with a long stretch free of idling on both sides
      if (phase == 2) quiet <= 1'b1;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        hold = ($urandom_range(99) < 8);
        send_item(pick_value(2000, wild), pick_value(300, wild), pick_step(wild), hold);
        if (!hold) sent++;
        if (quiet && sent == 150) quiet <= 1'b0;
      end
      wait_drained();
    end

    if (error_count == 0 && outstanding == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #50_000_000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

### altitude_complementary_filter_top.f
rtl/acf_pkg.sv
rtl/acf_serial_mult.sv
rtl/acf_core.sv
rtl/altitude_complementary_filter_top.sv
verif/altitude_filter_checker.sv
verif/altitude_complementary_filter_top_test.sv
